FILE: hdl/rstoi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rod strain time of impact: shared package
// Widths, constants, the job record that travels from the front to the back,
// and the state type of the back-end sequencer.
// ----------------------------------------------------------------------------
package rstoi_pkg;

	localparam int COORD_BITS     = 21;
	localparam int TIME_FRAC_BITS = 16;
	localparam int COORD_COUNT    = 3;

	// Fixed field widths of the ports.
	localparam int POS_W = 63;
	localparam int LEN_W = 21;
	localparam int CAP_W = 16;
	localparam int TIME_W = TIME_FRAC_BITS + 1;

	// One full time step and the strain factor of one that is added to the cap.
	localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(1) << TIME_FRAC_BITS;
	localparam logic [CAP_W-1:0] LIMIT_ONE = CAP_W'(4096);

	// Datapath widths.
	localparam int D_W    = COORD_BITS + 1;         // start edge vector component
	localparam int DD_W   = COORD_BITS + 2;         // edge motion component
	localparam int P_W    = COORD_BITS + 3;         // edge component at time t
	localparam int PROD_W = DD_W + TIME_W + 1;      // t times edge motion
	localparam int SQR_W  = 2 * P_W;                // one squared component
	localparam int SUM_W  = SQR_W + 2;              // squared length, Q20
	localparam int SQ_SHIFT = 24;                   // Q20 to Q44
	localparam int THR_W  = LEN_W + CAP_W;          // threshold length, Q22
	localparam int THR_LO = (THR_W + 1) / 2;
	localparam int THR_HI = THR_W - THR_LO;
	localparam int THR2_W = 2 * THR_W;              // squared threshold, Q44
	localparam int CMP_W  = (SUM_W + SQ_SHIFT > THR2_W) ? (SUM_W + SQ_SHIFT) : THR2_W;

	localparam logic signed [PROD_W-1:0] HALF_TIME = PROD_W'(1) << (TIME_FRAC_BITS - 1);

	// Job queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// Register port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_LSB = 2;
	localparam int CFG_IDX_W = CFG_ADDR_W - CFG_IDX_LSB;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME = CFG_IDX_W'(0);

	typedef struct packed {
		logic [COORD_COUNT-1:0][D_W-1:0]  d0;
		logic [COORD_COUNT-1:0][DD_W-1:0] dd;
		logic [LEN_W-1:0]                 len;
		logic [CAP_W-1:0]                 cap;
		logic [TIME_W-1:0]                top;
		logic                             bypass;
	} rstoi_job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_THR,
		ST_SQR,
		ST_SUM,
		ST_MUL,
		ST_SQ,
		ST_CMP,
		ST_FIN
	} rstoi_state_t;

endpackage

FILE: hdl/rstoi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rod strain time of impact: front end
// Takes input words, forms the edge vectors and the search top, and marks
// words that need no search.
// ----------------------------------------------------------------------------
module rstoi_front
	import rstoi_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [POS_W-1:0]        start_a,
	input  logic [POS_W-1:0]        start_b,
	input  logic [POS_W-1:0]        end_a,
	input  logic [POS_W-1:0]        end_b,
	input  logic [LEN_W-1:0]        rest_len,
	input  logic signed [CAP_W-1:0] strain_cap,
	input  logic [TIME_W-1:0]       max_time,
	output logic                    push_valid,
	input  logic                    push_ready,
	output rstoi_job_t              push_job
);

	rstoi_job_t job_c;
	rstoi_job_t job_s1;
	logic       valid_s1;

	always_comb begin
		logic signed [COORD_BITS-1:0] sa, sb, ea, eb;
		logic signed [D_W-1:0]        s_d, e_d;
		job_c = '0;
		for (int k = 0; k < COORD_COUNT; k++) begin
			sa = $signed(start_a[k*COORD_BITS +: COORD_BITS]);
			sb = $signed(start_b[k*COORD_BITS +: COORD_BITS]);
			ea = $signed(end_a[k*COORD_BITS +: COORD_BITS]);
			eb = $signed(end_b[k*COORD_BITS +: COORD_BITS]);
			s_d = D_W'(sb) - D_W'(sa);
			e_d = D_W'(eb) - D_W'(ea);
			job_c.d0[k] = s_d;
			job_c.dd[k] = DD_W'(e_d) - DD_W'(s_d);
		end
		job_c.len    = rest_len;
		job_c.cap    = strain_cap;
		job_c.top    = (max_time > TIME_ONE) ? TIME_ONE : max_time;
		job_c.bypass = strain_cap[CAP_W-1] || (strain_cap == '0) || (rest_len == '0);
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_job   = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_s1 <= job_c;
		end
	end

endmodule

FILE: hdl/rstoi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rod strain time of impact: job queue
// A short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module rstoi_queue
	import rstoi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  rstoi_job_t push_job,
	output logic       pop_valid,
	input  logic       pop_ready,
	output rstoi_job_t pop_job
);

	rstoi_job_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

FILE: hdl/rstoi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rod strain time of impact: back end
// Squares the strain threshold, then runs the bisection on one shared
// multiply, square and compare datapath, and holds the result for output.
// ----------------------------------------------------------------------------
module rstoi_back
	import rstoi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  rstoi_job_t        pop_job,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TIME_W-1:0] impact_time
);

	rstoi_state_t state_q, state_d;

	rstoi_job_t                job_q;
	logic [THR_W-1:0]          thr_q;
	logic [2*THR_HI-1:0]       hh_q;
	logic [THR_HI+THR_LO-1:0]  hl_q;
	logic [2*THR_LO-1:0]       ll_q;
	logic [THR2_W-1:0]         thr2_q;
	logic [TIME_W-1:0]         t_q, upper_q, lower_q, window_q, res_q;
	logic                      first_q;
	logic signed [PROD_W-1:0]  prod_s1 [COORD_COUNT];
	logic [SQR_W-1:0]          sq_s2 [COORD_COUNT];
	logic                      out_valid_q;
	logic [TIME_W-1:0]         out_time_q;

	logic signed [P_W-1:0]     p_c [COORD_COUNT];
	logic [SQR_W-1:0]          sq_c [COORD_COUNT];
	logic [SUM_W-1:0]          sum_c;
	logic                      over_c;
	logic [TIME_W-1:0]         nl_c, nu_c, nw_c, mid_c;
	logic [TIME_W:0]           pair_c;
	logic                      done_c;
	logic                      load_out;

	// Edge at the probe time, squared per component.
	always_comb begin
		logic signed [PROD_W-1:0] sh;
		for (int k = 0; k < COORD_COUNT; k++) begin
			sh = (prod_s1[k] + HALF_TIME) >>> TIME_FRAC_BITS;
			p_c[k] = P_W'($signed(job_q.d0[k])) + P_W'(sh);
			sq_c[k] = SQR_W'(SQR_W'(p_c[k]) * SQR_W'(p_c[k]));
		end
	end

	// Compare against the threshold and step the bracket.
	always_comb begin
		sum_c = '0;
		for (int k = 0; k < COORD_COUNT; k++) begin
			sum_c = sum_c + SUM_W'(sq_s2[k]);
		end
		over_c = ((CMP_W'(sum_c) << SQ_SHIFT) >= CMP_W'(thr2_q));
		nl_c   = over_c ? lower_q : t_q;
		nu_c   = over_c ? t_q : upper_q;
		nw_c   = nu_c - nl_c;
		pair_c = (TIME_W+1)'(nu_c) + (TIME_W+1)'(nl_c);
		mid_c  = pair_c[TIME_W:1];
		done_c = first_q ? !over_c : (nw_c == window_q);
	end

	assign load_out    = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign impact_time = out_time_q;

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = pop_job.bypass ? ST_FIN : ST_THR;
				end
			end
			ST_THR: state_d = ST_SQR;
			ST_SQR: state_d = ST_SUM;
			ST_SUM: state_d = ST_MUL;
			ST_MUL: state_d = ST_SQ;
			ST_SQ:  state_d = ST_CMP;
			ST_CMP: state_d = done_c ? ST_FIN : ST_MUL;
			ST_FIN: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_time_q <= res_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					job_q <= pop_job;
					res_q <= pop_job.top;
				end
			end
			ST_THR: begin
				thr_q <= THR_W'(job_q.len) * THR_W'(LIMIT_ONE + job_q.cap);
			end
			ST_SQR: begin
				hh_q <= (2*THR_HI)'(thr_q[THR_W-1:THR_LO]) * (2*THR_HI)'(thr_q[THR_W-1:THR_LO]);
				hl_q <= (THR_HI+THR_LO)'(thr_q[THR_W-1:THR_LO])
					* (THR_HI+THR_LO)'(thr_q[THR_LO-1:0]);
				ll_q <= (2*THR_LO)'(thr_q[THR_LO-1:0]) * (2*THR_LO)'(thr_q[THR_LO-1:0]);
			end
			ST_SUM: begin
				thr2_q   <= (THR2_W'(hh_q) << (2*THR_LO)) + (THR2_W'(hl_q) << (THR_LO+1))
					+ THR2_W'(ll_q);
				t_q      <= job_q.top;
				upper_q  <= job_q.top;
				lower_q  <= '0;
				window_q <= job_q.top;
				first_q  <= 1'b1;
			end
			ST_MUL: begin
				for (int k = 0; k < COORD_COUNT; k++) begin
					prod_s1[k] <= PROD_W'($signed({1'b0, t_q}))
						* PROD_W'($signed(job_q.dd[k]));
				end
			end
			ST_SQ: begin
				for (int k = 0; k < COORD_COUNT; k++) begin
					sq_s2[k] <= sq_c[k];
				end
			end
			ST_CMP: begin
				res_q   <= nl_c;
				upper_q <= nu_c;
				lower_q <= nl_c;
				t_q     <= mid_c;
				first_q <= 1'b0;
				if (!first_q) begin
					window_q <= nw_c;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hdl/rod_strain_time_of_impact.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rod strain time of impact
// Finds the last time at which a moving rod edge stays below its strain limit,
// by bisection on time, with a one-register APB-style configuration port.
// ----------------------------------------------------------------------------
// Each input word describes one rod edge. The result word is the top of the
// time search (max_time, capped at one full step) when the edge has no limit
// or stays below it at that top, and otherwise the last probed time below the
// limit found by bisection. The front end takes a word per cycle while its
// two-entry job queue has room, so input and output stall independently. The
// back end handles one word at a time: a word with no limit goes straight to
// its result, and a limited word first forms and squares its threshold, then
// runs its probes one at a time, because every probe goes through the one
// shared multiply, square and compare datapath. A full-step search makes
// about eighteen probes. max_time sits at byte address 0; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rod_strain_time_of_impact
	import rstoi_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// Input channel.
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [POS_W-1:0]        start_a,
	input  logic [POS_W-1:0]        start_b,
	input  logic [POS_W-1:0]        end_a,
	input  logic [POS_W-1:0]        end_b,
	input  logic [LEN_W-1:0]        rest_len,
	input  logic signed [CAP_W-1:0] strain_cap,
	// Output channel.
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [TIME_W-1:0]       impact_time,
	// Configuration port.
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [CFG_ADDR_W-1:0]   paddr,
	input  logic [CFG_DATA_W-1:0]   pwdata,
	output logic [CFG_DATA_W-1:0]   prdata,
	output logic                    pready
);

	logic [TIME_W-1:0] max_time_q;
	logic              reg_hit;

	logic       push_valid, push_ready;
	rstoi_job_t push_job;
	logic       pop_valid, pop_ready;
	rstoi_job_t pop_job;

	// The register index is the byte address divided by four.
	assign reg_hit = (paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_MAX_TIME);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? CFG_DATA_W'(max_time_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_time_q <= TIME_ONE;
		end else if (psel && penable && pwrite && reg_hit) begin
			max_time_q <= pwdata[TIME_W-1:0];
		end
	end

	// Front end: edge vectors, search top and the no-search mark.
	rstoi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_a    (start_a),
		.start_b    (start_b),
		.end_a      (end_a),
		.end_b      (end_b),
		.rest_len   (rest_len),
		.strain_cap (strain_cap),
		.max_time   (max_time_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// Jobs wait here while the back end is busy with a search.
	rstoi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// Back end: threshold squaring, bisection and the output register.
	rstoi_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_job     (pop_job),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.impact_time (impact_time)
	);

endmodule

FILE: verif/rstoi_impact_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rod strain time of impact: result checker
// Watches the register port and both word channels, predicts the impact time
// of every accepted edge word and compares it with the returned words in order.
// ----------------------------------------------------------------------------
module rstoi_impact_checker
	import rstoi_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [POS_W-1:0]        start_a,
	input  logic [POS_W-1:0]        start_b,
	input  logic [POS_W-1:0]        end_a,
	input  logic [POS_W-1:0]        end_b,
	input  logic [LEN_W-1:0]        rest_len,
	input  logic signed [CAP_W-1:0] strain_cap,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [TIME_W-1:0]       impact_time,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [CFG_ADDR_W-1:0]   paddr,
	input  logic [CFG_DATA_W-1:0]   pwdata,
	input  logic                    pready,
	output int                      failures,
	output int                      pending
);

	typedef logic [COORD_COUNT-1:0][63:0] rod3_t;

	logic [TIME_W-1:0] max_time_q = TIME_ONE;
	logic [TIME_W-1:0] impact_due[$];
	int                err_count = 0;

	function automatic longint coord(input logic [POS_W-1:0] pos, input int slot);
		logic signed [COORD_BITS-1:0] c;
		c = pos[slot*COORD_BITS +: COORD_BITS];
		return longint'(c);
	endfunction

	// True when the edge at time t is at or beyond its strain limit.
	function automatic logic over_limit(input rod3_t d0, input rod3_t dd, input longint t,
			input logic [127:0] thr_sq);
		longint       p;
		longint       half;
		logic [127:0] len_sq;
		half = longint'(1) <<< (TIME_FRAC_BITS - 1);
		len_sq = '0;
		for (int k = 0; k < COORD_COUNT; k++) begin
			p = $signed(d0[k]) + (($signed(dd[k]) * t + half) >>> TIME_FRAC_BITS);
			len_sq += 128'(p * p);
		end
		return (len_sq << 24) >= thr_sq;
	endfunction

	function automatic logic [TIME_W-1:0] time_of_impact(
			input logic [POS_W-1:0] sa, input logic [POS_W-1:0] sb,
			input logic [POS_W-1:0] ea, input logic [POS_W-1:0] eb,
			input logic [LEN_W-1:0] len, input logic signed [CAP_W-1:0] cap_in,
			input logic [TIME_W-1:0] top_reg);
		rod3_t        d0;
		rod3_t        dd;
		longint       top;
		longint       cap;
		longint       upper;
		longint       lower;
		longint       window;
		longint       t;
		logic [127:0] thr;
		logic [127:0] thr_sq;
		logic         done;
		top = (top_reg > TIME_ONE) ? longint'(TIME_ONE) : longint'(top_reg);
		cap = longint'(cap_in);
		if (cap <= 0 || len == '0)
			return TIME_W'(top);
		for (int k = 0; k < COORD_COUNT; k++) begin
			d0[k] = coord(sb, k) - coord(sa, k);
			dd[k] = (coord(eb, k) - coord(ea, k)) - $signed(d0[k]);
		end
		thr = 128'(len) * 128'(longint'(LIMIT_ONE) + cap);
		thr_sq = thr * thr;
		if (!over_limit(d0, dd, top, thr_sq))
			return TIME_W'(top);
		upper = top;
		lower = 0;
		window = upper - lower;
		done = 1'b0;
		while (!done) begin
			t = (upper + lower) >>> 1;
			if (!over_limit(d0, dd, t, thr_sq))
				lower = t;
			else
				upper = t;
			if (upper - lower == window)
				done = 1'b1;
			window = upper - lower;
		end
		return TIME_W'(lower);
	endfunction

	always @(posedge clk) begin
		logic [TIME_W-1:0] due;
		if (!arst_n) begin
			max_time_q = TIME_ONE;
			impact_due.delete();
		end else begin
			if (psel && penable && pwrite && pready &&
					paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_MAX_TIME)
				max_time_q = pwdata[TIME_W-1:0];
			if (in_valid && in_ready)
				impact_due.push_back(time_of_impact(start_a, start_b, end_a, end_b,
					rest_len, strain_cap, max_time_q));
			if (out_valid && out_ready) begin
				if (impact_due.size() == 0) begin
					$error("impact_time: unexpected word, expected none, actual %0d",
						impact_time);
					err_count++;
				end else begin
					due = impact_due.pop_front();
					if (impact_time !== due) begin
						$error("impact_time mismatch: expected %0d, actual %0d",
							due, impact_time);
						err_count++;
					end
				end
			end
		end
		failures <= err_count;
		pending <= impact_due.size();
	end

endmodule

FILE: verif/rod_strain_time_of_impact_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rod strain time of impact: testbench top
// Drives edge words and max_time settings into the block, idles both channels
// at random, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module rod_strain_time_of_impact_tb;
	import rstoi_pkg::*;

	// Cycle limit for the whole run, well above the slowest legal run.
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int HOLD_CYCLES     = 400;
	localparam int WORDS_PER_PHASE = 235;
	localparam int PHASES          = 8;
	localparam int SETTLE_CYCLES   = 100;
	localparam int ONE_LEN         = 1024;   // 1.0 in Q10.10
	localparam int COORD_MAX       = (1 << (COORD_BITS - 1)) - 1;
	localparam int COORD_MIN       = -(1 << (COORD_BITS - 1));

	typedef struct packed {
		logic [POS_W-1:0]        start_a;
		logic [POS_W-1:0]        start_b;
		logic [POS_W-1:0]        end_a;
		logic [POS_W-1:0]        end_b;
		logic [LEN_W-1:0]        rest_len;
		logic signed [CAP_W-1:0] strain_cap;
	} rod_word_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [POS_W-1:0]        start_a = '0;
	logic [POS_W-1:0]        start_b = '0;
	logic [POS_W-1:0]        end_a = '0;
	logic [POS_W-1:0]        end_b = '0;
	logic [LEN_W-1:0]        rest_len = '0;
	logic signed [CAP_W-1:0] strain_cap = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [TIME_W-1:0]       impact_time;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0]   paddr = '0;
	logic [CFG_DATA_W-1:0]   pwdata = '0;
	logic [CFG_DATA_W-1:0]   prdata;
	logic                    pready;

	int   failures;
	int   pending;
	int   cycle_count = 0;
	logic hold_req = 1'b0;
	logic tx_burst = 1'b0;

	rod_strain_time_of_impact uut (.*);

	rstoi_impact_checker chk (.*);

	always #4 clk = ~clk;

	// Guard against a hung handshake: anything past the limit is a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Most gaps are zero or short; about one in eight is long. A burst gives none.
	function automatic int idle_gap(input logic burst);
		int r;
		r = $urandom_range(0, 15);
		if (burst || r < 7)
			return 0;
		if (r < 14)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int rnd_signed(input int m);
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	// Packs three Q10.10 coordinates, x in the low bits.
	function automatic logic [POS_W-1:0] pos(input int x, input int y, input int z);
		return {COORD_BITS'(z), COORD_BITS'(y), COORD_BITS'(x)};
	endfunction

	function automatic rod_word_t make_word(input logic [POS_W-1:0] sa,
			input logic [POS_W-1:0] sb, input logic [POS_W-1:0] ea,
			input logic [POS_W-1:0] eb, input int len, input int cap);
		rod_word_t w;
		w.start_a = sa;
		w.start_b = sb;
		w.end_a = ea;
		w.end_b = eb;
		w.rest_len = LEN_W'(len);
		w.strain_cap = CAP_W'(cap);
		return w;
	endfunction

	// Random edge words. Most are plausible rods: the start length sits near
	// or under the rest length and the end length often crosses the limit, so
	// the bisection runs deep. The rest is raw noise over every bit.
	function automatic rod_word_t random_word();
		rod_word_t w;
		int        len;
		int        m0;
		int        m1;
		int        ax, ay, az, bx, by, bz;
		if ($urandom_range(0, 9) < 3) begin
			w.start_a = POS_W'({$urandom, $urandom});
			w.start_b = POS_W'({$urandom, $urandom});
			w.end_a = POS_W'({$urandom, $urandom});
			w.end_b = POS_W'({$urandom, $urandom});
			w.rest_len = LEN_W'($urandom);
			w.strain_cap = CAP_W'($urandom);
			return w;
		end
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 1 << 18);
		m0 = ($urandom_range(0, 7) == 0) ? 2 * len : len / 2;
		m1 = len * $urandom_range(1, 4) / 2;
		ax = rnd_signed((1 << 19) - 1);
		ay = rnd_signed((1 << 19) - 1);
		az = rnd_signed((1 << 19) - 1);
		bx = rnd_signed((1 << 19) - 1);
		by = rnd_signed((1 << 19) - 1);
		bz = rnd_signed((1 << 19) - 1);
		w.start_a = pos(ax, ay, az);
		w.start_b = pos(ax + rnd_signed(m0), ay + rnd_signed(m0), az + rnd_signed(m0));
		w.end_a = pos(bx, by, bz);
		w.end_b = pos(bx + rnd_signed(m1), by + rnd_signed(m1), bz + rnd_signed(m1));
		w.rest_len = LEN_W'(len);
		w.strain_cap = CAP_W'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 32767) :
			$urandom_range(1, 4096));
		return w;
	endfunction

	// Presents one word and returns at the edge where it is taken. Valid is
	// left high so the next word can follow without a bubble.
	task automatic send_word(input rod_word_t w);
		in_valid <= 1'b1;
		start_a <= w.start_a;
		start_b <= w.start_b;
		end_a <= w.end_a;
		end_b <= w.end_b;
		rest_len <= w.rest_len;
		strain_cap <= w.strain_cap;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause(input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops the sender until every outstanding word has come back. The first
	// edge lets the checker count a word taken at the current edge.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_max_time(input logic [CFG_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(REG_MAX_TIME) << CFG_IDX_LSB;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Receiver: random runs of ready with stalls between them, some long
	// runs with no stall at all, and one long hold-off when requested so the
	// block backs up and stops taking words.
	initial begin
		int   run;
		int   stall;
		logic held;
		held = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				run = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 200) :
					$urandom_range(1, 6);
				out_ready <= 1'b1;
				repeat (run) @(posedge clk);
				stall = idle_gap(1'b0);
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] top_setting[PHASES];
		rod_word_t             directed[$];
		logic                  holding;

		// Phase 0 runs on the reset value; the others cover both ends of the
		// range, a value past one full step with junk in the unused bits, and
		// random points on either side of one step.
		top_setting[0] = 32'd65536;
		top_setting[1] = 32'd0;
		top_setting[2] = 32'd1;
		top_setting[3] = (32'($urandom) & 32'hFFFE_0000) | 32'h0001_FFFF;
		top_setting[4] = 32'd65535;
		top_setting[5] = $urandom_range(2, 65535);
		top_setting[6] = $urandom_range(65537, 131070);
		top_setting[7] = 32'd65536;

		// No limit: zero, most negative and minus one strain cap, zero rest length.
		directed.push_back(make_word(pos(0, 0, 0), pos(ONE_LEN, 0, 0), pos(0, 0, 0),
			pos(5 * ONE_LEN, 0, 0), ONE_LEN, 0));
		directed.push_back(make_word(pos(0, 0, 0), pos(ONE_LEN, 0, 0), pos(0, 0, 0),
			pos(5 * ONE_LEN, 0, 0), ONE_LEN, -32768));
		directed.push_back(make_word(pos(0, 0, 0), pos(ONE_LEN, 0, 0), pos(0, 0, 0),
			pos(5 * ONE_LEN, 0, 0), ONE_LEN, -1));
		directed.push_back(make_word(pos(0, 0, 0), pos(ONE_LEN, 0, 0), pos(0, 0, 0),
			pos(5 * ONE_LEN, 0, 0), 0, 4096));
		// Stays below the limit over the whole step.
		directed.push_back(make_word(pos(0, 0, 0), pos(ONE_LEN, 0, 0), pos(0, 0, 0),
			pos(1126, 0, 0), ONE_LEN, 4096));
		// Already over at the start, and exactly at the limit at the start.
		directed.push_back(make_word(pos(0, 0, 0), pos(3 * ONE_LEN, 0, 0), pos(0, 0, 0),
			pos(3 * ONE_LEN, 0, 0), ONE_LEN, 410));
		directed.push_back(make_word(pos(0, 0, 0), pos(2 * ONE_LEN, 0, 0), pos(0, 0, 0),
			pos(4 * ONE_LEN, 0, 0), ONE_LEN, 4096));
		// Crosses the limit part way through, along x and then along y and z.
		directed.push_back(make_word(pos(0, 0, 0), pos(ONE_LEN, 0, 0), pos(0, 0, 0),
			pos(3 * ONE_LEN, 0, 0), ONE_LEN, 2048));
		directed.push_back(make_word(pos(100, -200, 300), pos(100, 300, 800),
			pos(-50, 40, 0), pos(-50, 2000, 1960), ONE_LEN, 1));
		// Shrinking edge: over at the start but below again at the top.
		directed.push_back(make_word(pos(0, 0, 0), pos(3 * ONE_LEN, 0, 0), pos(0, 0, 0),
			pos(ONE_LEN / 2, 0, 0), ONE_LEN, 410));
		// Flips through zero length and out the other side.
		directed.push_back(make_word(pos(0, 0, 0), pos(ONE_LEN / 2, 0, 0), pos(0, 0, 0),
			pos(-3 * ONE_LEN, 0, 0), ONE_LEN, 1024));
		// Zero-length edge with the smallest limit.
		directed.push_back(make_word(pos(7, 7, 7), pos(7, 7, 7), pos(-9, 3, 1),
			pos(-9, 3, 1), 1, 1));
		// Coordinate extremes with the largest and the smallest limit.
		directed.push_back(make_word(pos(COORD_MAX, COORD_MAX, COORD_MAX),
			pos(COORD_MIN, COORD_MIN, COORD_MIN), pos(COORD_MIN, COORD_MIN, COORD_MIN),
			pos(COORD_MAX, COORD_MAX, COORD_MAX), (1 << LEN_W) - 1, 32767));
		directed.push_back(make_word(pos(COORD_MAX, COORD_MAX, COORD_MAX),
			pos(COORD_MIN, COORD_MIN, COORD_MIN), pos(COORD_MIN, COORD_MIN, COORD_MIN),
			pos(COORD_MAX, COORD_MAX, COORD_MAX), 1, 1));
		directed.push_back(make_word(pos(COORD_MIN, COORD_MAX, COORD_MIN),
			pos(COORD_MAX, COORD_MIN, COORD_MAX), pos(COORD_MAX, COORD_MIN, COORD_MAX),
			pos(COORD_MIN, COORD_MAX, COORD_MIN), (1 << LEN_W) - 1, 1));
		// All ones in every field, once limited and once with no limit.
		directed.push_back(make_word('1, '1, '1, '1, (1 << LEN_W) - 1, 32767));
		directed.push_back(make_word('1, '1, '1, '1, (1 << LEN_W) - 1, -1));

		// Single reset pulse at the start of the run.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_word(directed[i]);
			pause(idle_gap(1'b0));
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			// Register writes happen only with nothing in flight.
			if (ph != 0) begin
				drain();
				write_max_time(top_setting[ph]);
			end
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				if (i % 50 == 0)
					tx_burst = ($urandom_range(0, 3) == 0);
				// Long receiver hold-off while words keep coming back to back.
				holding = (ph == 4 && i >= 50 && i < 90);
				send_word(random_word());
				if (ph == 4 && i == 50)
					hold_req <= 1'b1;
				if (ph == 5 && i == 120)
					drain();
				else if (!holding)
					pause(idle_gap(tx_burst));
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
